@@ hdl/vlr_pkg.sv @@
// ----------------------------------------------------------------------------
// vlr_pkg: shared types and constants for the vector length rescaler
// Widths of the component, product, sum-of-squares and root datapaths.
// ----------------------------------------------------------------------------
package vlr_pkg;

   localparam int COMP_WIDTH = 32;
   localparam int PROD_WIDTH = 2 * COMP_WIDTH;
   localparam int SUM_WIDTH  = 2 * COMP_WIDTH + 2;
   localparam int ROOT_STEPS = SUM_WIDTH / 2;
   localparam int REM_WIDTH  = COMP_WIDTH + 4;
   localparam int DIV_STEPS  = COMP_WIDTH;

   typedef logic [COMP_WIDTH-1:0] comp_type;
   typedef logic [PROD_WIDTH-1:0] prod_type;
   typedef logic [SUM_WIDTH-1:0]  sum_type;

   typedef struct packed {
      logic big;
      logic neg;
   } div_flags_type;

   function automatic comp_type magnitude(comp_type v);
      return v[COMP_WIDTH-1] ? comp_type'(0) - v : v;
   endfunction

endpackage

@@ hdl/vlr_lane.sv @@
// ----------------------------------------------------------------------------
// vlr_lane: per-component front end
// Takes magnitudes, then forms the square and the product with the target.
// ----------------------------------------------------------------------------
module vlr_lane (
   input  logic               clock,
   input  vlr_pkg::comp_type  comp,
   input  vlr_pkg::comp_type  target,
   output vlr_pkg::prod_type  square,
   output vlr_pkg::prod_type  product,
   output logic               neg
);

   vlr_pkg::comp_type mag_ff, tmag_ff;
   logic              neg1_ff;
   vlr_pkg::prod_type square_ff, product_ff;
   logic              neg2_ff;

   always_ff @(posedge clock) begin
      mag_ff     <= vlr_pkg::magnitude(comp);
      tmag_ff    <= vlr_pkg::magnitude(target);
      neg1_ff    <= comp[vlr_pkg::COMP_WIDTH-1] ^ target[vlr_pkg::COMP_WIDTH-1];
      square_ff  <= vlr_pkg::PROD_WIDTH'(mag_ff) * vlr_pkg::PROD_WIDTH'(mag_ff);
      product_ff <= vlr_pkg::PROD_WIDTH'(mag_ff) * vlr_pkg::PROD_WIDTH'(tmag_ff);
      neg2_ff    <= neg1_ff;
   end

   assign square  = square_ff;
   assign product = product_ff;
   assign neg     = neg2_ff;

endmodule

@@ hdl/vlr_sqrt.sv @@
// ----------------------------------------------------------------------------
// vlr_sqrt: pipelined integer square root
// One root bit per stage, restoring digit recurrence, truncated result.
// ----------------------------------------------------------------------------
module vlr_sqrt (
   input  logic              clock,
   input  vlr_pkg::sum_type  radicand,
   output vlr_pkg::comp_type root
);

   localparam int S  = vlr_pkg::ROOT_STEPS;
   localparam int RW = vlr_pkg::REM_WIDTH;

   vlr_pkg::sum_type rad_ff  [1:S];
   logic [RW-1:0]    rem_ff  [1:S];
   logic [S-1:0]     root_ff [1:S];

   for (genvar k = 1; k <= S; k++) begin : g_stage
      vlr_pkg::sum_type rad_prev;
      logic [RW-1:0]    rem_prev, rem_sh, trial;
      logic [S-1:0]     root_prev;
      if (k == 1) begin : g_first
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end
      always_comb begin
         rem_sh = {rem_prev[RW-3:0], rad_prev[vlr_pkg::SUM_WIDTH-1 -: 2]};
         trial  = RW'({root_prev, 2'b01});
      end
      always_ff @(posedge clock) begin
         rad_ff[k] <= {rad_prev[vlr_pkg::SUM_WIDTH-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff[k]  <= rem_sh - trial;
            root_ff[k] <= {root_prev[S-2:0], 1'b1};
         end else begin
            rem_ff[k]  <= rem_sh;
            root_ff[k] <= {root_prev[S-2:0], 1'b0};
         end
      end
   end

   assign root = root_ff[S][vlr_pkg::COMP_WIDTH-1:0];

endmodule

@@ hdl/vlr_div.sv @@
// ----------------------------------------------------------------------------
// vlr_div: pipelined divider for one lane
// Flags a quotient of 2^W or more up front, then yields W quotient bits.
// ----------------------------------------------------------------------------
module vlr_div (
   input  logic                   clock,
   input  vlr_pkg::prod_type      num,
   input  vlr_pkg::comp_type      den,
   input  logic                   neg,
   output vlr_pkg::comp_type      quot,
   output vlr_pkg::div_flags_type flags
);

   localparam int W = vlr_pkg::COMP_WIDTH;
   localparam int S = vlr_pkg::DIV_STEPS;

   vlr_pkg::comp_type      rem_ff   [0:S];
   vlr_pkg::comp_type      low_ff   [0:S];
   vlr_pkg::comp_type      den_ff   [0:S];
   vlr_pkg::comp_type      quot_ff  [0:S];
   vlr_pkg::div_flags_type flags_ff [0:S];

   always_ff @(posedge clock) begin
      rem_ff[0]       <= num[2*W-1:W];
      low_ff[0]       <= num[W-1:0];
      den_ff[0]       <= den;
      quot_ff[0]      <= '0;
      flags_ff[0].big <= num[2*W-1:W] >= den;
      flags_ff[0].neg <= neg;
   end

   for (genvar k = 1; k <= S; k++) begin : g_stage
      logic [W:0] r2;
      assign r2 = {rem_ff[k-1], low_ff[k-1][W-1]};
      always_ff @(posedge clock) begin
         low_ff[k]   <= {low_ff[k-1][W-2:0], 1'b0};
         den_ff[k]   <= den_ff[k-1];
         flags_ff[k] <= flags_ff[k-1];
         if (r2 >= {1'b0, den_ff[k-1]}) begin
            rem_ff[k]  <= W'(r2 - {1'b0, den_ff[k-1]});
            quot_ff[k] <= {quot_ff[k-1][W-2:0], 1'b1};
         end else begin
            rem_ff[k]  <= r2[W-1:0];
            quot_ff[k] <= {quot_ff[k-1][W-2:0], 1'b0};
         end
      end
   end

   assign quot  = quot_ff[S];
   assign flags = flags_ff[S];

endmodule

@@ hdl/vector_length_rescale.sv @@
// ----------------------------------------------------------------------------
// vector_length_rescale: rescale a 3-component Q16.16 vector to a length
// Three lanes square and scale the components, a shared root pipeline finds
// the length, and three divider lanes finish; results merge at the output.
// ----------------------------------------------------------------------------
// A new item is taken every cycle (busy is always low) and its result leaves
// on rsp_valid for a single cycle, after the magnitude, product and sum
// registers, 33 root stages (one root bit each), 33 divider stages and the output
// register. The receiver cannot stall, so every strobe must be taken.
module vector_length_rescale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [vlr_pkg::COMP_WIDTH-1:0] req_comp_x,
   input  logic signed [vlr_pkg::COMP_WIDTH-1:0] req_comp_y,
   input  logic signed [vlr_pkg::COMP_WIDTH-1:0] req_comp_z,
   input  logic signed [vlr_pkg::COMP_WIDTH-1:0] req_target_length,
   output logic                                 rsp_valid,
   output logic [vlr_pkg::COMP_WIDTH-1:0]        rsp_orig_length,
   output logic signed [vlr_pkg::COMP_WIDTH-1:0] rsp_out_x,
   output logic signed [vlr_pkg::COMP_WIDTH-1:0] rsp_out_y,
   output logic signed [vlr_pkg::COMP_WIDTH-1:0] rsp_out_z,
   output logic                                 rsp_zero_vector,
   output logic                                 rsp_saturated
);

   localparam int W   = vlr_pkg::COMP_WIDTH;
   localparam int PD  = vlr_pkg::ROOT_STEPS + 1;
   localparam int DD  = vlr_pkg::DIV_STEPS + 1;
   localparam int LAT = 3 + vlr_pkg::ROOT_STEPS + DD + 1;
   localparam vlr_pkg::comp_type POS_MAX = {1'b0, {(W-1){1'b1}}};
   localparam vlr_pkg::comp_type NEG_MAG = {1'b1, {(W-1){1'b0}}};

   vlr_pkg::comp_type comps [3];
   vlr_pkg::prod_type sq [3];
   vlr_pkg::prod_type pr [3];
   logic              ng [3];

   assign comps[0] = req_comp_x;
   assign comps[1] = req_comp_y;
   assign comps[2] = req_comp_z;
   assign busy     = 1'b0;

   vlr_pkg::sum_type  sum_ff;
   vlr_pkg::comp_type root;
   vlr_pkg::prod_type pr_ff [0:PD-1][3];
   logic              ng_ff [0:PD-1][3];
   vlr_pkg::comp_type len_ff [0:DD-1];
   logic [LAT-1:0]    valid_ff;

   vlr_pkg::comp_type      quot  [3];
   vlr_pkg::div_flags_type flags [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vlr_lane u_lane (
         .clock(clock), .comp(comps[i]), .target(req_target_length),
         .square(sq[i]), .product(pr[i]), .neg(ng[i])
      );
      vlr_div u_div (
         .clock(clock), .num(pr_ff[PD-1][i]), .den(root), .neg(ng_ff[PD-1][i]),
         .quot(quot[i]), .flags(flags[i])
      );
   end

   vlr_sqrt u_sqrt (.clock(clock), .radicand(sum_ff), .root(root));

   always_ff @(posedge clock) begin
      sum_ff <= vlr_pkg::SUM_WIDTH'(sq[0]) + vlr_pkg::SUM_WIDTH'(sq[1])
              + vlr_pkg::SUM_WIDTH'(sq[2]);
      for (int i = 0; i < 3; i++) begin
         pr_ff[0][i] <= pr[i];
         ng_ff[0][i] <= ng[i];
         for (int d = 1; d < PD; d++) begin
            pr_ff[d][i] <= pr_ff[d-1][i];
            ng_ff[d][i] <= ng_ff[d-1][i];
         end
      end
      len_ff[0] <= root;
      for (int d = 1; d < DD; d++) len_ff[d] <= len_ff[d-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start};
      end
   end

   vlr_pkg::comp_type res_in [3];
   logic              sat_in;
   logic              zero_in;
   vlr_pkg::comp_type res_ff [3];
   logic              sat_ff, zero_ff;
   vlr_pkg::comp_type length_ff;

   always_comb begin
      zero_in = len_ff[DD-1] == '0;
      sat_in  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (zero_in) begin
            res_in[i] = '0;
         end else if (flags[i].neg) begin
            if (flags[i].big || quot[i] > NEG_MAG) begin
               res_in[i] = NEG_MAG;
               sat_in    = 1'b1;
            end else begin
               res_in[i] = vlr_pkg::comp_type'(0) - quot[i];
            end
         end else begin
            if (flags[i].big || quot[i] > POS_MAX) begin
               res_in[i] = POS_MAX;
               sat_in    = 1'b1;
            end else begin
               res_in[i] = quot[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff    <= res_in;
      sat_ff    <= sat_in;
      zero_ff   <= zero_in;
      length_ff <= len_ff[DD-1];
   end

   assign rsp_valid       = valid_ff[LAT-1];
   assign rsp_orig_length = length_ff;
   assign rsp_out_x       = res_ff[0];
   assign rsp_out_y       = res_ff[1];
   assign rsp_out_z       = res_ff[2];
   assign rsp_zero_vector = zero_ff;
   assign rsp_saturated   = sat_ff;

`ifndef SYNTHESIS
   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |->
         rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0 && !rsp_saturated)
      else $error("zero vector result not clean");
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_zero_vector == (rsp_orig_length == '0))
      else $error("zero flag disagrees with length");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start ##(LAT) 1'b1 |-> rsp_valid)
      else $error("result strobe missing");
`endif

endmodule
